// ===== rtl/core/crdg_pkg.sv =====
// crdg_pkg: types and constants for the camera ray direction generator
// no dependencies; imported by camera_ray_direction_generator_top
`default_nettype none
package crdg_pkg;

   // frame size clamp and output fraction bits
   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 14;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_RIGHT_AXIS   = 3'd0,
      REG_UP_AXIS      = 3'd1,
      REG_FORWARD_AXIS = 3'd2,
      REG_TAN_HORIZ    = 3'd3,
      REG_TAN_VERT     = 3'd4,
      REG_FRAME_WIDTH  = 3'd5,
      REG_FRAME_HEIGHT = 3'd6
   } reg_index_type;

   // request payload
   typedef struct packed {
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
   } req_type;

   // result payload
   typedef struct packed {
      logic signed [15:0] dir_z;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_x;
   } rsp_type;

   // normalized magnitudes with signs, carried past the square root
   typedef struct packed {
      logic [2:0][29:0] mag;
      logic [2:0]       neg;
      logic             zero;
   } norm_type;

endpackage
`default_nettype wire

// ===== rtl/core/camera_ray_direction_generator_top.sv =====
// camera_ray_direction_generator_top: pinhole camera primary ray directions
// depends on crdg_pkg
`default_nettype none
// Usage:
//   request channel: a pixel (req_data) is taken at a clock edge where start
//   is high and busy is low; busy stays low, so a pixel may enter every cycle.
//   result channel: rsp_valid marks rsp_data for one cycle; the receiver
//   cannot hold it off and none is needed.
//   csr port: csr_we writes csr_wdata into register csr_index at once;
//   write only while no request is in flight.
// Throughput: one request per cycle.
// Pipeline: an accepted request passes, on its way to rsp_valid, through
//   ten stages of setup, products and normalization, 32 stages of the
//   bit-per-stage square root and 18 stages of the bit-per-stage divider,
//   plus the output register.
// Reset: synchronous; clears all pipeline valid bits and loads the default
//   camera (identity basis, unit tangents, 640 x 480).
module camera_ray_direction_generator_top
   import crdg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   localparam int QW  = FRAC_BITS + 3;
   localparam int RW  = 32 + QW;
   localparam int NSQ = 32;

   logic [47:0] right_ff, up_ff, fwd_ff;
   logic [15:0] tanh_ff, tanv_ff;
   logic [12:0] width_ff, height_ff;
   logic [12:0] w_eff, h_eff;

   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff  <= 48'd16384;
         up_ff     <= 48'd1073741824;
         fwd_ff    <= 48'd70368744177664;
         tanh_ff   <= 16'd256;
         tanv_ff   <= 16'd256;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RIGHT_AXIS:   right_ff  <= csr_wdata;
            REG_UP_AXIS:      up_ff     <= csr_wdata;
            REG_FORWARD_AXIS: fwd_ff    <= csr_wdata;
            REG_TAN_HORIZ:    tanh_ff   <= csr_wdata[15:0];
            REG_TAN_VERT:     tanv_ff   <= csr_wdata[15:0];
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata[12:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // frame size clamped to 1..MAX_DIM
   always_comb begin
      priority if (width_ff == 13'd0) w_eff = 13'd1;
      else if (width_ff > 13'(MAX_DIM)) w_eff = 13'(MAX_DIM);
      else w_eff = width_ff;
      priority if (height_ff == 13'd0) h_eff = 13'd1;
      else if (height_ff > 13'(MAX_DIM)) h_eff = 13'(MAX_DIM);
      else h_eff = height_ff;
   end

   // stage 1: centered pixel offsets
   logic               v1_ff;
   logic signed [14:0] nx_ff, ny_ff;
   always_ff @(posedge clock) begin
      v1_ff <= reset ? 1'b0 : (start & ~busy);
      nx_ff <= $signed({2'b00, req_data.pixel_col, 1'b1}) - $signed({2'b00, w_eff});
      ny_ff <= $signed({2'b00, h_eff}) - $signed({2'b00, req_data.pixel_row, 1'b1});
   end

   // stage 2: offsets times tangents, frame area
   logic               v2_ff;
   logic signed [31:0] p_ff, q_ff;
   logic [25:0]        wh_ff;
   always_ff @(posedge clock) begin
      v2_ff <= reset ? 1'b0 : v1_ff;
      p_ff  <= 32'(nx_ff * $signed({1'b0, tanh_ff}));
      q_ff  <= 32'(ny_ff * $signed({1'b0, tanv_ff}));
      wh_ff <= 26'({13'd0, w_eff} * {13'd0, h_eff});
   end

   // stage 3: cross-scale by the other frame dimension
   logic               v3_ff;
   logic signed [45:0] a_ff, b_ff;
   logic signed [34:0] c_ff;
   always_ff @(posedge clock) begin
      v3_ff <= reset ? 1'b0 : v2_ff;
      a_ff  <= 46'(p_ff * $signed({1'b0, h_eff}));
      b_ff  <= 46'(q_ff * $signed({1'b0, w_eff}));
      c_ff  <= $signed({1'b0, wh_ff, 8'd0});
   end

   // stage 4: scale the basis vectors
   logic               v4_ff;
   logic signed [61:0] pa_ff [3];
   logic signed [61:0] pb_ff [3];
   logic signed [61:0] pc_ff [3];
   always_ff @(posedge clock) begin
      v4_ff <= reset ? 1'b0 : v3_ff;
      for (int i = 0; i < 3; i++) begin
         pa_ff[i] <= 62'(a_ff * $signed(right_ff[16*i +: 16]));
         pb_ff[i] <= 62'(b_ff * $signed(up_ff[16*i +: 16]));
         pc_ff[i] <= 62'(c_ff * $signed(fwd_ff[16*i +: 16]));
      end
   end

   // stage 5: sum into the direction, split sign and magnitude
   logic        v5_ff;
   logic [63:0] mag5_ff [3];
   logic [2:0]  neg5_ff;
   always_ff @(posedge clock) begin
      v5_ff <= reset ? 1'b0 : v4_ff;
      for (int i = 0; i < 3; i++) begin
         logic signed [63:0] sum_v;
         sum_v = 64'(pa_ff[i]) + 64'(pb_ff[i]) + 64'(pc_ff[i]);
         neg5_ff[i] <= sum_v[63];
         mag5_ff[i] <= sum_v[63] ? 64'(-sum_v) : 64'(sum_v);
      end
   end

   // stage 6: largest magnitude
   logic        v6_ff;
   logic [63:0] mag6_ff [3];
   logic [63:0] mx6_ff;
   logic [2:0]  neg6_ff;
   always_ff @(posedge clock) begin
      logic [63:0] m01;
      v6_ff   <= reset ? 1'b0 : v5_ff;
      m01     = (mag5_ff[0] > mag5_ff[1]) ? mag5_ff[0] : mag5_ff[1];
      mx6_ff  <= (m01 > mag5_ff[2]) ? m01 : mag5_ff[2];
      mag6_ff <= mag5_ff;
      neg6_ff <= neg5_ff;
   end

   // stage 7: leading zero count of the largest magnitude
   logic        v7_ff;
   logic [63:0] mag7_ff [3];
   logic [2:0]  neg7_ff;
   logic [5:0]  lz7_ff;
   logic        zero7_ff;
   always_ff @(posedge clock) begin
      logic [5:0] lz_v;
      lz_v = 6'd0;
      for (int j = 0; j < 64; j++) begin
         if (mx6_ff[j]) lz_v = 6'(63 - j);
      end
      v7_ff    <= reset ? 1'b0 : v6_ff;
      mag7_ff  <= mag6_ff;
      neg7_ff  <= neg6_ff;
      lz7_ff   <= lz_v;
      zero7_ff <= (mx6_ff == 64'd0);
   end

   // stage 8: common shift puts the largest top bit at bit 29
   logic     v8_ff;
   norm_type n8_ff;
   always_ff @(posedge clock) begin
      logic [63:0] sh_v;
      v8_ff <= reset ? 1'b0 : v7_ff;
      for (int i = 0; i < 3; i++) begin
         sh_v = mag7_ff[i] << lz7_ff;
         n8_ff.mag[i] <= sh_v[63:34];
      end
      n8_ff.neg  <= neg7_ff;
      n8_ff.zero <= zero7_ff;
   end

   // stage 9: squares
   logic        v9_ff;
   norm_type    n9_ff;
   logic [59:0] sq9_ff [3];
   always_ff @(posedge clock) begin
      v9_ff <= reset ? 1'b0 : v8_ff;
      n9_ff <= n8_ff;
      for (int i = 0; i < 3; i++) begin
         sq9_ff[i] <= 60'({30'd0, n8_ff.mag[i]} * {30'd0, n8_ff.mag[i]});
      end
   end

   // square root pipeline, one result bit per stage; index 0 holds the sum
   logic        sv_ff  [NSQ+1];
   logic [63:0] ss_ff  [NSQ+1];
   logic [63:0] sr_ff  [NSQ+1];
   norm_type    sn_ff  [NSQ+1];

   always_ff @(posedge clock) begin
      sv_ff[0] <= reset ? 1'b0 : v9_ff;
      ss_ff[0] <= 64'(sq9_ff[0]) + 64'(sq9_ff[1]) + 64'(sq9_ff[2]);
      sr_ff[0] <= 64'd0;
      sn_ff[0] <= n9_ff;
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      localparam logic [63:0] SqBit = 64'd1 << (62 - 2*k);
      logic [63:0] trial;
      assign trial = sr_ff[k] + SqBit;
      always_ff @(posedge clock) begin
         sv_ff[k+1] <= reset ? 1'b0 : sv_ff[k];
         sn_ff[k+1] <= sn_ff[k];
         if (ss_ff[k] >= trial) begin
            ss_ff[k+1] <= ss_ff[k] - trial;
            sr_ff[k+1] <= (sr_ff[k] >> 1) + SqBit;
         end else begin
            ss_ff[k+1] <= ss_ff[k];
            sr_ff[k+1] <= sr_ff[k] >> 1;
         end
      end
   end

   // divider pipeline, one quotient bit per stage; index 0 holds the operands
   logic          dv_ff   [QW+1];
   logic [31:0]   dd_ff   [QW+1];
   logic [RW-1:0] drem_ff [QW+1][3];
   logic [QW-1:0] dq_ff   [QW+1][3];
   logic [2:0]    dneg_ff [QW+1];
   logic          dzero_ff[QW+1];

   always_ff @(posedge clock) begin
      dv_ff[0]    <= reset ? 1'b0 : sv_ff[NSQ];
      dd_ff[0]    <= {sr_ff[NSQ][30:0], 1'b0};
      dneg_ff[0]  <= sn_ff[NSQ].neg;
      dzero_ff[0] <= sn_ff[NSQ].zero;
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= RW'({sn_ff[NSQ].mag[i], (FRAC_BITS + 1)'(0)})
                          + RW'(sr_ff[NSQ][31:0]);
         dq_ff[0][i]   <= '0;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      logic [RW-1:0] dsh;
      assign dsh = RW'(dd_ff[g]) << (QW - 1 - g);
      always_ff @(posedge clock) begin
         dv_ff[g+1]    <= reset ? 1'b0 : dv_ff[g];
         dd_ff[g+1]    <= dd_ff[g];
         dneg_ff[g+1]  <= dneg_ff[g];
         dzero_ff[g+1] <= dzero_ff[g];
         for (int i = 0; i < 3; i++) begin
            if (drem_ff[g][i] >= dsh) begin
               drem_ff[g+1][i] <= drem_ff[g][i] - dsh;
               dq_ff[g+1][i]   <= {dq_ff[g][i][QW-2:0], 1'b1};
            end else begin
               drem_ff[g+1][i] <= drem_ff[g][i];
               dq_ff[g+1][i]   <= {dq_ff[g][i][QW-2:0], 1'b0};
            end
         end
      end
   end

   // output: sign, saturation, zero direction
   logic [15:0] res_v [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QW-1:0] qv;
         qv = dq_ff[QW][i];
         if (dzero_ff[QW]) res_v[i] = 16'd0;
         else if (dneg_ff[QW][i])
            res_v[i] = (qv > QW'(32768)) ? 16'h8000 : 16'(~qv + 1'b1);
         else
            res_v[i] = (qv > QW'(32767)) ? 16'h7fff : qv[15:0];
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      rsp_valid_ff      <= reset ? 1'b0 : dv_ff[QW];
      rsp_data_ff.dir_x <= res_v[0];
      rsp_data_ff.dir_y <= res_v[1];
      rsp_data_ff.dir_z <= res_v[2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
